>>> src/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/dcd_pkg.sv
// shared constants and types for the dfs cycle detector
package dcd_pkg;

    // default and limits of the node count
    localparam int MAX_NODES_DEF = 32;
    localparam int ROW_W         = 32;
    localparam int NODE_CNT_W    = 6;
    localparam logic [NODE_CNT_W-1:0] NODE_CNT_RST = 6'd32;

    // configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic REG_NODE_COUNT = 1'b0;

    // loader to search engine
    typedef struct packed {
        logic clear;
        logic go;
    } t_srch_cmd;

    // search engine to top
    typedef struct packed {
        logic busy;
        logic done;
        logic cyclic;
    } t_srch_rsp;

endpackage

>>> src/dcd_ram.sv
// generic single write port ram with registered read
module dcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/dcd_apb_regs.sv
// apb configuration register holding the node count
module dcd_apb_regs #(
    parameter int MAX_NODES = dcd_pkg::MAX_NODES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dcd_pkg::CFG_AW-1:0]    paddr,
    input  logic [dcd_pkg::CFG_DW-1:0]    pwdata,
    output logic [dcd_pkg::CFG_DW-1:0]    prdata,
    output logic                          pready,
    output logic [$clog2(MAX_NODES+1)-1:0] o_node_n
);
    import dcd_pkg::*;

    localparam int CW = $clog2(MAX_NODES + 1);

    logic [NODE_CNT_W-1:0] r_node_cnt;
    logic [NODE_CNT_W-1:0] n_node_cnt;
    logic                  wr_en;
    logic                  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    // register write
    always_comb begin
        n_node_cnt = r_node_cnt;
        if (wr_en && (reg_idx == REG_NODE_COUNT)) begin
            n_node_cnt = pwdata[NODE_CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_cnt <= NODE_CNT_RST;
        end else begin
            r_node_cnt <= n_node_cnt;
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (reg_idx == REG_NODE_COUNT) begin
            prdata = CFG_DW'(r_node_cnt);
        end
    end

    // node count saturated to the supported node limit
    always_comb begin
        if (int'(r_node_cnt) > MAX_NODES) begin
            o_node_n = CW'(MAX_NODES);
        end else begin
            o_node_n = CW'(r_node_cnt);
        end
    end
endmodule

>>> src/dcd_search.sv
// depth-first search sequencer with the stack in a ram
module dcd_search #(
    parameter int MAX_NODES = dcd_pkg::MAX_NODES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dcd_pkg::t_srch_cmd                i_cmd,
    input  logic [$clog2(MAX_NODES+1)-1:0]    i_node_n,
    output logic                              o_adj_re,
    output logic [$clog2(MAX_NODES)-1:0]      o_adj_raddr,
    input  logic [dcd_pkg::ROW_W-1:0]         i_adj_rdata,
    output dcd_pkg::t_srch_rsp                o_rsp
);
    import dcd_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int SW = 2 * NW + CW + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ROOT  = 5'b00010,
        S_FETCH = 5'b00100,
        S_SCAN  = 5'b01000,
        S_POP   = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_root, n_root;
    logic [CW-1:0]        r_sp, n_sp;
    logic [NW-1:0]        r_top_node, n_top_node;
    logic [CW-1:0]        r_top_col, n_top_col;
    logic [NW-1:0]        r_par_node, n_par_node;
    logic                 r_has_par, n_has_par;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [MAX_NODES-1:0] r_visited, n_visited;
    logic                 r_done, n_done;
    logic                 r_cyclic, n_cyclic;

    logic [MAX_NODES-1:0] row_cols;
    logic [NW-1:0]        col_idx;
    logic [CW-1:0]        col_inc;
    logic [CW-1:0]        sp_m1;
    logic [CW-1:0]        sp_m2;
    logic                 stk_we;
    logic                 stk_re;
    logic [SW-1:0]        stk_wdata;
    logic [SW-1:0]        stk_rdata;

    // columns beyond the row width read as no edge
    for (genvar gi = 0; gi < MAX_NODES; gi++) begin : g_col
        if (gi < ROW_W) begin : g_in
            assign row_cols[gi] = r_row[gi];
        end else begin : g_out
            assign row_cols[gi] = 1'b0;
        end
    end

    assign col_idx   = r_top_col[NW-1:0];
    assign col_inc   = r_top_col + CW'(1);
    assign sp_m1     = r_sp - CW'(1);
    assign sp_m2     = r_sp - CW'(2);
    assign stk_wdata = {r_top_node, col_inc, r_has_par, r_par_node};

    // stack below the top entry; each entry keeps its own parent
    dcd_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_NODES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (sp_m1[NW-1:0]),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (sp_m2[NW-1:0]),
        .o_rdata (stk_rdata)
    );

    // search sequencer
    always_comb begin
        n_state     = r_state;
        n_root      = r_root;
        n_sp        = r_sp;
        n_top_node  = r_top_node;
        n_top_col   = r_top_col;
        n_par_node  = r_par_node;
        n_has_par   = r_has_par;
        n_row       = r_row;
        n_visited   = r_visited;
        n_done      = 1'b0;
        n_cyclic    = r_cyclic;
        stk_we      = 1'b0;
        stk_re      = 1'b0;
        o_adj_re    = 1'b0;
        o_adj_raddr = r_root[NW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_cmd.clear) begin
                    n_visited = '0;
                end
                if (i_cmd.go) begin
                    n_root  = '0;
                    n_state = S_ROOT;
                end
            end

            // pick the next unvisited root or finish acyclic
            S_ROOT: begin
                if (r_root >= i_node_n) begin
                    n_done   = 1'b1;
                    n_cyclic = 1'b0;
                    n_state  = S_IDLE;
                end else if (r_visited[r_root[NW-1:0]]) begin
                    n_root = r_root + CW'(1);
                end else begin
                    n_visited[r_root[NW-1:0]] = 1'b1;
                    n_top_node = r_root[NW-1:0];
                    n_top_col  = '0;
                    n_has_par  = 1'b0;
                    n_sp       = CW'(1);
                    o_adj_re   = 1'b1;
                    n_state    = S_FETCH;
                end
            end

            // capture the adjacency row of the new top node
            S_FETCH: begin
                n_row   = i_adj_rdata;
                n_state = S_SCAN;
            end

            // one column of the top node per cycle
            S_SCAN: begin
                if (r_top_col >= i_node_n) begin
                    if (r_sp == CW'(1)) begin
                        n_sp    = '0;
                        n_state = S_ROOT;
                    end else begin
                        n_sp    = sp_m1;
                        stk_re  = 1'b1;
                        n_state = S_POP;
                    end
                end else begin
                    n_top_col = col_inc;
                    if (row_cols[col_idx]) begin
                        if (!r_visited[col_idx]) begin
                            // push: spill the top entry and descend
                            stk_we     = 1'b1;
                            n_visited[col_idx] = 1'b1;
                            n_par_node = r_top_node;
                            n_has_par  = 1'b1;
                            n_top_node = col_idx;
                            n_top_col  = '0;
                            n_sp       = r_sp + CW'(1);
                            o_adj_re    = 1'b1;
                            o_adj_raddr = col_idx;
                            n_state    = S_FETCH;
                        end else if (!(r_has_par && (r_par_node == col_idx))) begin
                            n_done   = 1'b1;
                            n_cyclic = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                end
            end

            // restore the entry below and refetch its row
            S_POP: begin
                n_top_node  = stk_rdata[SW-1 -: NW];
                n_top_col   = stk_rdata[NW+CW : NW+1];
                n_has_par   = stk_rdata[NW];
                n_par_node  = stk_rdata[NW-1:0];
                o_adj_re    = 1'b1;
                o_adj_raddr = stk_rdata[SW-1 -: NW];
                n_state     = S_FETCH;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_root    <= '0;
            r_sp      <= '0;
            r_visited <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_root    <= n_root;
            r_sp      <= n_sp;
            r_visited <= n_visited;
            r_done    <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_top_node <= n_top_node;
        r_top_col  <= n_top_col;
        r_par_node <= n_par_node;
        r_has_par  <= n_has_par;
        r_row      <= n_row;
        r_cyclic   <= n_cyclic;
    end

    assign o_rsp.busy   = (r_state != S_IDLE);
    assign o_rsp.done   = r_done;
    assign o_rsp.cyclic = r_cyclic;
endmodule

>>> src/dfs_cycle_detect_top.sv
// top level of the dfs cycle detector: row loader, adjacency ram and search
//
//  channel   signals                              handshake
//  --------  -----------------------------------  ------------------------------
//  rows      i_row_edges, i_last_row              start high while busy low
//  result    o_cyclic                             o_done, one cycle, no stall
//  config    psel penable pwrite paddr pwdata     apb write, pready tied high
//
// a row is taken while start is high and busy low, and is written to the adjacency
// ram in the same cycle while the row count is below the node limit. after the last
// row the search runs: it probes the roots in turn, fetches a node's row, scans one
// column per cycle and pops to refetch the row below; the column scan dominates.
// reset is synchronous and needs no clearing pass; busy stays low except
// during the search, and o_done follows the search's final cycle.
module dfs_cycle_detect_top #(
    parameter int MAX_NODES = dcd_pkg::MAX_NODES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [dcd_pkg::ROW_W-1:0]  i_row_edges,
    input  logic                       i_last_row,
    output logic                       o_done,
    output logic                       o_cyclic,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dcd_pkg::CFG_AW-1:0] paddr,
    input  logic [dcd_pkg::CFG_DW-1:0] pwdata,
    output logic [dcd_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);
    import dcd_pkg::*;

`include "assert_macros.svh"

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    logic [CW-1:0] r_row_cnt, n_row_cnt;
    logic [CW-1:0] node_n;
    logic          accept;
    logic          adj_we;
    logic          adj_re;
    logic [NW-1:0] adj_raddr;
    logic [ROW_W-1:0] adj_rdata;
    t_srch_cmd     cmd;
    t_srch_rsp     rsp;

    // configuration register
    dcd_apb_regs #(
        .MAX_NODES (MAX_NODES)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_node_n (node_n)
    );

    // row loader
    assign accept    = start && !busy;
    assign adj_we    = accept && (r_row_cnt < CW'(MAX_NODES));
    assign cmd.clear = accept && (r_row_cnt == '0);
    assign cmd.go    = accept && i_last_row;

    always_comb begin
        n_row_cnt = r_row_cnt;
        if (accept) begin
            if (i_last_row) begin
                n_row_cnt = '0;
            end else if (r_row_cnt < CW'(MAX_NODES)) begin
                n_row_cnt = r_row_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
        end else begin
            r_row_cnt <= n_row_cnt;
        end
    end

    // adjacency matrix, one row per entry
    dcd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_NODES)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (r_row_cnt[NW-1:0]),
        .i_wdata (i_row_edges),
        .i_re    (adj_re),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    // search engine
    dcd_search #(
        .MAX_NODES (MAX_NODES)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_node_n    (node_n),
        .o_adj_re    (adj_re),
        .o_adj_raddr (adj_raddr),
        .i_adj_rdata (adj_rdata),
        .o_rsp       (rsp)
    );

    assign busy     = rsp.busy;
    assign o_done   = rsp.done;
    assign o_cyclic = rsp.cyclic;

    // checks
    `ASSERT_NEXT(a_last_row_starts_search, i_clk, i_rst_n, accept && i_last_row, busy, "search did not start after last row")
    `ASSERT_NEXT(a_done_follows_search, i_clk, i_rst_n, !busy && !(accept && i_last_row), !o_done, "result without a search")
    `ASSERT_ALWAYS(a_row_cnt_bound, i_clk, i_rst_n, r_row_cnt <= CW'(MAX_NODES), "row counter past node limit")
endmodule

>>> tb/testbench.sv
// self-checking testbench for the dfs cycle detector: row loads, search results, node count
`timescale 1ns / 1ps

module testbench;
    import dcd_pkg::*;

    // timing and run control
    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 1500;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int TIMEOUT_NS    = 20_000_000;
    localparam int MAX_REPORTS   = 10;
    localparam int STEADY_FROM   = 300;
    localparam int STEADY_TO     = 450;

    // register map
    localparam int REG_SPARE = 1;
    localparam logic [CFG_AW-1:0] ADDR_NODE_COUNT = CFG_AW'(4 * REG_NODE_COUNT);
    localparam logic [CFG_AW-1:0] ADDR_SPARE      = CFG_AW'(4 * REG_SPARE);

    // kinds of graph the generator builds
    typedef enum int {
        GR_FOREST,
        GR_FOREST_CHORD,
        GR_SELF_LOOP,
        GR_SYM_RANDOM,
        GR_ASYM_RANDOM,
        GR_EMPTY,
        GR_COMPLETE
    } t_graph_style;

    // one row item as the driver sends it
    typedef struct packed {
        logic [ROW_W-1:0] edges;
        logic             last_flag;
    } t_row_item;

    // block ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic [ROW_W-1:0]      i_row_edges = '0;
    logic                  i_last_row  = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [CFG_AW-1:0]     paddr       = '0;
    logic [CFG_DW-1:0]     pwdata      = '0;
    logic                  busy;
    logic                  o_done;
    logic                  o_cyclic;
    logic [CFG_DW-1:0]     prdata;
    logic                  pready;

    // stimulus bookkeeping
    t_row_item             row_feed [$];
    t_row_item             next_item;
    int                    issued_count   = 0;
    int                    accepted_count = 0;
    int                    items_queued   = 0;
    int                    load_len       = 0;
    int                    rows_written   = 0;
    logic [ROW_W-1:0]      graph_rows [MAX_NODES_DEF];

    // predictor state
    logic [NODE_CNT_W-1:0] cfg_node_count = NODE_CNT_RST;
    logic [ROW_W-1:0]      adjacency_rows [MAX_NODES_DEF];
    logic [MAX_NODES_DEF-1:0] visited_nodes = '0;
    int                    row_slot = 0;
    bit                    cyclic_verdicts [$];
    bit                    verdict_head;
    int                    mismatch_count = 0;

    dfs_cycle_detect_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_row_edges (i_row_edges),
        .i_last_row  (i_last_row),
        .o_done      (o_done),
        .o_cyclic    (o_cyclic),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // node count actually searched, saturated at the node limit
    function automatic int used_nodes(input logic [NODE_CNT_W-1:0] count);
        return (count > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(count);
    endfunction

    // depth-first search over the stored rows, true on the first back edge
    function automatic bit dfs_finds_cycle(input int n);
        int          root;
        int          sp;
        int          top;
        int          v;
        int          w;
        logic [5:0]  stk_node [MAX_NODES_DEF];
        logic [5:0]  stk_col  [MAX_NODES_DEF];
        for (root = 0; root < n; root++) begin
            if (visited_nodes[root]) continue;
            visited_nodes[root] = 1'b1;
            stk_node[0] = root[5:0];
            stk_col[0]  = '0;
            sp = 1;
            while (sp > 0) begin
                top = sp - 1;
                v = int'(stk_node[top]);
                w = int'(stk_col[top]);
                if (w >= n) begin
                    sp--;
                    continue;
                end
                stk_col[top] = stk_col[top] + 6'd1;
                if (!adjacency_rows[v][w]) continue;
                if (!visited_nodes[w]) begin
                    // descend into an unvisited neighbor
                    visited_nodes[w] = 1'b1;
                    if (sp < MAX_NODES_DEF) begin
                        stk_node[sp] = w[5:0];
                        stk_col[sp]  = '0;
                        sp++;
                    end
                end else if (!(sp >= 2 && int'(stk_node[top - 1]) == w)) begin
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // store one accepted row and, on the last row, predict the verdict
    task automatic absorb_row(input logic [ROW_W-1:0] row, input logic last_flag);
        if (row_slot == 0) visited_nodes = '0;
        if (row_slot < MAX_NODES_DEF) begin
            adjacency_rows[row_slot] = row;
            row_slot++;
        end
        if (last_flag) begin
            cyclic_verdicts.push_back(dfs_finds_cycle(used_nodes(cfg_node_count)));
            row_slot = 0;
        end
    endtask

    task automatic note_mismatch(input string what, input bit want, input logic got);
        if (mismatch_count < MAX_REPORTS)
            $display("cyclic mismatch (%s): expected %0b, got %0b", what, want, got);
        mismatch_count++;
    endtask

    // driver: one row item per handshake, random gaps outside the steady stretch
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && issued_count != accepted_count) begin
            // item still waiting for the block
        end else if (row_feed.size() != 0 &&
                     ((issued_count >= STEADY_FROM && issued_count < STEADY_TO) ||
                      $urandom_range(0, 99) >= 33)) begin
            next_item = row_feed.pop_front();
            start        <= 1'b1;
            i_row_edges  <= next_item.edges;
            i_last_row   <= next_item.last_flag;
            issued_count <= issued_count + 1;
        end else begin
            start       <= 1'b0;
            i_row_edges <= $urandom();
            i_last_row  <= $urandom_range(0, 1);
        end
    end

    // monitor: check results, then feed accepted items to the predictor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                if (cyclic_verdicts.size() == 0) begin
                    note_mismatch("no load pending", 1'b0, o_cyclic);
                end else begin
                    verdict_head = cyclic_verdicts.pop_front();
                    if (o_cyclic !== verdict_head)
                        note_mismatch("search verdict", verdict_head, o_cyclic);
                end
            end
            if (start && !busy) begin
                absorb_row(i_row_edges, i_last_row);
                accepted_count <= accepted_count + 1;
            end
        end
    end

    // apb write: setup cycle, then access cycle until pready
    task automatic write_config(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_NODE_COUNT) cfg_node_count = data[NODE_CNT_W-1:0];
    endtask

    // queue one row item and track which rows have been written since reset
    task automatic queue_row(input logic [ROW_W-1:0] row, input logic last_flag);
        t_row_item item;
        item.edges     = row;
        item.last_flag = last_flag;
        row_feed.push_back(item);
        items_queued++;
        load_len++;
        if (last_flag) begin
            if (load_len > MAX_NODES_DEF) load_len = MAX_NODES_DEF;
            if (load_len > rows_written) rows_written = load_len;
            load_len = 0;
        end
    endtask

    // build a random graph over n nodes and queue it as one load
    task automatic queue_graph(input int n);
        t_graph_style      style;
        int                pick;
        int                k;
        int                r;
        int                a;
        int                b;
        int                dens;
        bit                noisy;
        logic [ROW_W-1:0]  col_mask;
        logic [ROW_W-1:0]  row_val;
        for (r = 0; r < MAX_NODES_DEF; r++) graph_rows[r] = '0;
        pick = $urandom_range(0, 99);
        if (pick < 25)      style = GR_FOREST;
        else if (pick < 50) style = GR_FOREST_CHORD;
        else if (pick < 60) style = GR_SELF_LOOP;
        else if (pick < 75) style = GR_SYM_RANDOM;
        else if (pick < 90) style = GR_ASYM_RANDOM;
        else if (pick < 95) style = GR_EMPTY;
        else                style = GR_COMPLETE;

        // trees first, then the extra edge that may close a cycle
        if (style == GR_FOREST || style == GR_FOREST_CHORD || style == GR_SELF_LOOP) begin
            for (r = 1; r < n; r++) begin
                if ($urandom_range(0, 9) < 7) begin
                    a = $urandom_range(0, r - 1);
                    graph_rows[r][a] = 1'b1;
                    graph_rows[a][r] = 1'b1;
                end
            end
        end
        case (style)
            GR_FOREST_CHORD: begin
                if (n >= 3) begin
                    a = $urandom_range(0, n - 1);
                    b = (a + $urandom_range(1, n - 1)) % n;
                    graph_rows[a][b] = 1'b1;
                    graph_rows[b][a] = 1'b1;
                end
            end
            GR_SELF_LOOP: begin
                if (n >= 1) begin
                    a = $urandom_range(0, n - 1);
                    graph_rows[a][a] = 1'b1;
                end
            end
            GR_SYM_RANDOM: begin
                dens = $urandom_range(3, 60);
                for (a = 0; a < n; a++)
                    for (b = a + 1; b < n; b++)
                        if ($urandom_range(0, 99) < dens) begin
                            graph_rows[a][b] = 1'b1;
                            graph_rows[b][a] = 1'b1;
                        end
            end
            GR_ASYM_RANDOM: begin
                for (r = 0; r < n; r++) graph_rows[r] = $urandom() & $urandom();
            end
            GR_COMPLETE: begin
                for (r = 0; r < n; r++) begin
                    graph_rows[r] = '1;
                    graph_rows[r][r] = 1'b0;
                end
            end
            default: ;
        endcase

        // load length: mostly exact, sometimes short or overlong
        pick = $urandom_range(0, 99);
        if (n == 0)
            k = $urandom_range(1, 3);
        else if (pick < 12 && rows_written >= n && n > 1)
            k = $urandom_range(1, n - 1);
        else if (pick >= 97 && n <= 8)
            k = MAX_NODES_DEF + $urandom_range(1, 4);
        else if (pick >= 90)
            k = n + $urandom_range(1, 5);
        else
            k = n;

        col_mask = (n >= ROW_W) ? '1 : ((32'd1 << n) - 32'd1);
        noisy = $urandom_range(0, 1);
        for (r = 0; r < k; r++) begin
            if (r < n)
                row_val = (graph_rows[r] & col_mask) | (noisy ? ($urandom() & ~col_mask) : '0);
            else
                row_val = $urandom();
            queue_row(row_val, r == k - 1);
        end
    endtask

    // wait until every queued item is taken and every verdict has arrived
    task automatic wait_drained();
        while (row_feed.size() != 0 || issued_count != accepted_count ||
               cyclic_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one random phase at a given node count
    task automatic run_phase(input logic [NODE_CNT_W-1:0] count, input int items);
        int target;
        if ($urandom_range(0, 3) == 0) write_config(ADDR_SPARE, $urandom());
        write_config(ADDR_NODE_COUNT, {(CFG_DW - NODE_CNT_W)'($urandom()), count});
        @(posedge i_clk);
        target = items_queued + items;
        while (items_queued < target) queue_graph(used_nodes(cfg_node_count));
        wait_drained();
    endtask

    // main sequence
    initial begin : main_seq
        int waited;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single node: empty, self loop, ignored columns, all ones
        write_config(ADDR_NODE_COUNT, 32'd1);
        queue_row(32'h0000_0000, 1'b1);
        queue_row(32'h0000_0001, 1'b1);
        queue_row(32'hFFFF_FFFE, 1'b1);
        queue_row(32'hFFFF_FFFF, 1'b1);
        wait_drained();

        // write to an unused register, then zero nodes
        write_config(ADDR_SPARE, 32'h0000_0005);
        write_config(ADDR_NODE_COUNT, 32'd0);
        queue_row(32'hFFFF_FFFF, 1'b1);
        wait_drained();

        // two nodes joined by one edge: the parent edge is not a cycle
        write_config(ADDR_NODE_COUNT, 32'd2);
        queue_row(32'h0000_0002, 1'b0);
        queue_row(32'h0000_0001, 1'b1);
        wait_drained();

        // three nodes: triangle, path, one-way edges, short load, all ones
        write_config(ADDR_NODE_COUNT, 32'd3);
        queue_row(32'h0000_0006, 1'b0);
        queue_row(32'h0000_0005, 1'b0);
        queue_row(32'h0000_0003, 1'b1);
        queue_row(32'h0000_0002, 1'b0);
        queue_row(32'h0000_0005, 1'b0);
        queue_row(32'h0000_0002, 1'b1);
        queue_row(32'h0000_0002, 1'b0);
        queue_row(32'h0000_0000, 1'b0);
        queue_row(32'h0000_0002, 1'b1);
        queue_row(32'h0000_0000, 1'b1);
        queue_row(32'hFFFF_FFFF, 1'b0);
        queue_row(32'hFFFF_FFFF, 1'b0);
        queue_row(32'hFFFF_FFFF, 1'b1);
        wait_drained();

        // random phases across node counts, extremes included
        run_phase(6'd5, 70);
        run_phase(6'd32, 70);
        run_phase(6'd2, 60);
        run_phase(6'd63, 70);
        run_phase(6'd8, 70);
        run_phase(6'd1, 40);
        run_phase(6'd16, 70);
        run_phase(6'd0, 30);
        run_phase(6'd12, 70);
        run_phase(6'd4, 70);
        run_phase(6'd24, 60);
        run_phase(6'd3, 60);
        run_phase(6'd32, 40);

        // final drain with a bound, then the tail
        waited = 0;
        while ((row_feed.size() != 0 || issued_count != accepted_count ||
                cyclic_verdicts.size() != 0) && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (cyclic_verdicts.size() != 0) begin
            $display("%0d search results never arrived", cyclic_verdicts.size());
            mismatch_count += cyclic_verdicts.size();
        end
        if (waited >= DRAIN_LIMIT) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/dcd_pkg.sv
src/dcd_ram.sv
src/dcd_apb_regs.sv
src/dcd_search.sv
src/dfs_cycle_detect_top.sv
tb/testbench.sv
